FILE: rtl/ftd_pkg.sv
package ftd_pkg;

    // Field widths of the frame interface
    localparam int MEAN_W  = 16;
    localparam int CHG_W   = 24;
    localparam int DELTA_W = 17;
    localparam int SUM_W   = 23;
    localparam int THR_W   = 22;
    localparam int DARK_W  = 16;
    localparam int WLEN_W  = 7;
    localparam int CFG_W   = 24;

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = MEAN_W + CHG_W;
    localparam int OUT_FIELDS_W = 1 + DELTA_W + SUM_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Sliding window geometry
    localparam int MAX_WINDOW = 64;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W      = $clog2(MAX_WINDOW);

    // Saturation bound of the running sum
    localparam int SUM_LIMIT = 4194303;

    // Reset value of the window length register
    localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = WLEN_W'(60);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAFE_AREA   = 2'd0,
        REG_FLASH_THR   = 2'd1,
        REG_DARK_THR    = 2'd2,
        REG_WINDOW_LEN  = 2'd3
    } cfg_reg_t;

    // Per-cell control of the window chain
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

FILE: rtl/flash_transition_detector.sv
// Path: an accepted request passes the stage one, stage two and output registers in order
// before m_tvalid rises. Throughput: one request per cycle unless the output stalls;
// the accumulate step over the window chain is done within stage two. Each stage holds
// its request until the next stage frees, so bubbles are squeezed out.
// Reset: asynchronous, active low; means, sum and window clear, window length returns to 60.
// Reset leaves the other configuration registers at zero and the pipeline empty.
module flash_transition_detector
    import ftd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // frame_mean[15:0], changed_pixels[39:16]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // is_transition[0], frame_delta[17:1], running_sum[40:18], zero padding above
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [CHG_W-1:0]          safe_area_reg;
    logic [THR_W-1:0]          flash_thr_reg;
    logic [DARK_W-1:0]         dark_thr_reg;
    logic [WLEN_W-1:0]         window_len_reg;

    logic [MEAN_W-1:0]         frame_mean;
    logic [CHG_W-1:0]          changed_pixels;
    logic [MEAN_W-1:0]         cur_mean_reg;
    logic signed [DELTA_W-1:0] delta_in;
    logic [MEAN_W-1:0]         darker_in;

    logic                      v1_reg;
    logic signed [DELTA_W-1:0] delta1_reg;
    logic [MEAN_W-1:0]         darker1_reg;
    logic                      v2_reg;
    logic signed [DELTA_W-1:0] delta2_reg;
    logic [MEAN_W-1:0]         darker2_reg;
    logic signed [SUM_W-1:0]   prev2_reg;
    logic signed [SUM_W-1:0]   sum2_reg;
    logic                      out_valid_reg;
    logic                      out_flag_reg;
    logic signed [DELTA_W-1:0] out_delta_reg;
    logic signed [SUM_W-1:0]   out_sum_reg;

    logic                      out_ready;
    logic                      ready2;
    logic                      ready1;
    logic                      adv1;
    logic                      adv2;
    logic                      adv3;
    logic signed [SUM_W-1:0]   prev_sum;
    logic signed [SUM_W-1:0]   new_sum;
    logic signed [SUM_W-1:0]   prev_neg;
    logic signed [SUM_W-1:0]   sum_neg;
    logic [THR_W-1:0]          mag_prev;
    logic [THR_W-1:0]          mag_sum;
    logic                      flag;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_area_reg  <= '0;
            flash_thr_reg  <= '0;
            dark_thr_reg   <= '0;
            window_len_reg <= WINDOW_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SAFE_AREA:  safe_area_reg  <= cfg_data[CHG_W-1:0];
                REG_FLASH_THR:  flash_thr_reg  <= cfg_data[THR_W-1:0];
                REG_DARK_THR:   dark_thr_reg   <= cfg_data[DARK_W-1:0];
                REG_WINDOW_LEN: window_len_reg <= cfg_data[WLEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Handshake across the three stages.
    assign out_ready = !out_valid_reg || m_tready;
    assign ready2    = !v2_reg || out_ready;
    assign ready1    = !v1_reg || ready2;
    assign s_tready  = ready1;
    assign adv1      = s_tvalid && ready1;
    assign adv2      = v1_reg && ready2;
    assign adv3      = v2_reg && out_ready;

    // Stage one: frame difference and darker mean.
    assign frame_mean     = s_tdata[MEAN_W-1:0];
    assign changed_pixels = s_tdata[IN_FIELDS_W-1:MEAN_W];
    assign delta_in       = (changed_pixels >= safe_area_reg)
                          ? ($signed({1'b0, frame_mean}) - $signed({1'b0, cur_mean_reg}))
                          : '0;
    assign darker_in      = (cur_mean_reg < frame_mean) ? cur_mean_reg : frame_mean;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mean_reg <= '0;
            v1_reg       <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                cur_mean_reg <= frame_mean;
            end
            if (adv1)
            begin
                v1_reg <= 1'b1;
            end
            else if (adv2)
            begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            delta1_reg  <= delta_in;
            darker1_reg <= darker_in;
        end
    end

    // Stage two: the sliding window and the running sum.
    ftd_window u_window
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (adv2),
        .delta      (delta1_reg),
        .window_len (window_len_reg),
        .prev_sum   (prev_sum),
        .new_sum    (new_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv2)
        begin
            v2_reg <= 1'b1;
        end
        else if (adv3)
        begin
            v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            delta2_reg  <= delta1_reg;
            darker2_reg <= darker1_reg;
            prev2_reg   <= prev_sum;
            sum2_reg    <= new_sum;
        end
    end

    // Stage three: threshold tests on the old and new sums.
    always_comb
    begin
        prev_neg = -prev2_reg;
        sum_neg  = -sum2_reg;
        mag_prev = prev2_reg[SUM_W-1] ? prev_neg[THR_W-1:0] : prev2_reg[THR_W-1:0];
        mag_sum  = sum2_reg[SUM_W-1]  ? sum_neg[THR_W-1:0]  : sum2_reg[THR_W-1:0];
        flag     = !((prev2_reg[SUM_W-1] == sum2_reg[SUM_W-1]) && (mag_prev >= flash_thr_reg))
                && (mag_sum >= flash_thr_reg)
                && (darker2_reg < dark_thr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv3)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            out_flag_reg  <= flag;
            out_delta_reg <= delta2_reg;
            out_sum_reg   <= sum2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_sum_reg, out_delta_reg,
                       out_flag_reg};

`ifndef NO_ASSERTIONS
    // An empty output register lets every stage move, so the input side is ready.
    assert property (@(posedge clk) disable iff (!rst_n) !m_tvalid |-> s_tready)
        else $error("input not ready while the output register is empty");

    // The running sum never takes the one code below the saturation bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_sum_reg != -SUM_W'(SUM_LIMIT) - SUM_W'(1)))
        else $error("running sum outside its saturation range");

    // A request in stage one that cannot move on is still there next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (v1_reg && !ready2) |=> v1_reg)
        else $error("stage one request lost while stalled");
`endif

endmodule

FILE: rtl/ftd_cell.sv
module ftd_cell
    import ftd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_ctrl_t                ctrl,
    input  logic signed [DELTA_W-1:0] delta,
    input  logic signed [DELTA_W-1:0] neighbour,
    output logic signed [DELTA_W-1:0] value
);

    logic signed [DELTA_W-1:0] value_reg;

    // A new difference is written here, or the entry moves one place towards the head.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (ctrl.load)
        begin
            value_reg <= delta;
        end
        else if (ctrl.shift)
        begin
            value_reg <= neighbour;
        end
    end

    assign value = value_reg;

endmodule

FILE: rtl/ftd_window.sv
module ftd_window
    import ftd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic signed [DELTA_W-1:0] delta,
    input  logic [WLEN_W-1:0]         window_len,
    output logic signed [SUM_W-1:0]   prev_sum,
    output logic signed [SUM_W-1:0]   new_sum
);

    localparam int LEN_W = (WLEN_W > CNT_W) ? WLEN_W : CNT_W;
    localparam int EXT_W = SUM_W + 1;
    localparam logic signed [EXT_W-1:0] LIMIT_X     = EXT_W'(SUM_LIMIT);
    localparam logic signed [EXT_W-1:0] NEG_LIMIT_X = -EXT_W'(SUM_LIMIT);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          count_dec;
    logic signed [SUM_W-1:0]   acc_reg;
    logic signed [SUM_W-1:0]   acc_next;
    logic [LEN_W-1:0]          len_wide;
    logic [LEN_W-1:0]          len_clip;
    logic [CNT_W-1:0]          len_eff;
    logic                      same_sign;
    logic                      pop;
    logic                      restart;
    logic [IDX_W-1:0]          wr_idx;
    logic signed [EXT_W-1:0]   acc_x;
    logic signed [EXT_W-1:0]   old_x;
    logic signed [EXT_W-1:0]   delta_x;
    logic signed [EXT_W-1:0]   raw_sum;
    logic signed [SUM_W-1:0]   clamped;
    logic signed [DELTA_W-1:0] cell_value [MAX_WINDOW];

    // Effective window length: zero reads as one, large values as the full chain.
    always_comb
    begin
        len_wide = LEN_W'(window_len);
        if (len_wide == '0)
        begin
            len_clip = LEN_W'(1);
        end
        else if (len_wide > LEN_W'(MAX_WINDOW))
        begin
            len_clip = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len_clip = len_wide;
        end
        len_eff = CNT_W'(len_clip);
    end

    // Sign test, oldest entry drop and write position.
    assign same_sign = (acc_reg[SUM_W-1] == delta[DELTA_W-1]);
    assign restart   = !same_sign;
    assign pop       = same_sign && (count_reg >= len_eff);
    assign count_dec = count_reg - CNT_W'(1);
    assign wr_idx    = pop ? count_dec[IDX_W-1:0] : count_reg[IDX_W-1:0];

    // Running sum, popped oldest entry removed, saturated; sign flip restarts.
    always_comb
    begin
        acc_x   = {acc_reg[SUM_W-1], acc_reg};
        old_x   = pop ? {{(EXT_W-DELTA_W){cell_value[0][DELTA_W-1]}}, cell_value[0]} : '0;
        delta_x = {{(EXT_W-DELTA_W){delta[DELTA_W-1]}}, delta};
        raw_sum = acc_x - old_x + delta_x;
        if (raw_sum > LIMIT_X)
        begin
            clamped = SUM_W'(LIMIT_X);
        end
        else if (raw_sum < NEG_LIMIT_X)
        begin
            clamped = SUM_W'(NEG_LIMIT_X);
        end
        else
        begin
            clamped = raw_sum[SUM_W-1:0];
        end
        acc_next = same_sign ? clamped : SUM_W'(delta_x);
    end

    // Fill count of the window.
    always_comb
    begin
        count_next = count_reg;
        if (step)
        begin
            if (restart)
            begin
                count_next = CNT_W'(1);
            end
            else if (!pop && (count_reg != CNT_W'(MAX_WINDOW)))
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
            acc_reg   <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            acc_reg   <= acc_next;
        end
    end

    // Chain of window cells, the oldest entry in cell zero.
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        cell_ctrl_t                ctrl;
        logic signed [DELTA_W-1:0] neighbour;

        assign ctrl.load  = step && (restart ? (i == 0) : (wr_idx == IDX_W'(i)));
        assign ctrl.shift = step && pop;

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign neighbour = '0;
        end
        else
        begin : g_mid
            assign neighbour = cell_value[i+1];
        end

        ftd_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .delta     (delta),
            .neighbour (neighbour),
            .value     (cell_value[i])
        );
    end

    assign prev_sum = acc_reg;
    assign new_sum  = acc_next;

endmodule
